// ===== hdl/ip6p_pkg.sv =====
// Shared types, character codes and helpers for the IPv6 text address parser.
`timescale 1ns / 1ps

package ip6p_pkg;

  localparam int NumBytes = 16;

  // Character codes.
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;

  // Link-local prefix bytes.
  localparam logic [7:0] LinkLocalB0 = 8'hfe;
  localparam logic [7:0] LinkLocalB1 = 8'h80;

  localparam logic [8:0] OctetMax = 9'd255;
  localparam logic [8:0] DecSat   = 9'd256;
  localparam logic [3:0] DecRadix = 4'd10;

  typedef enum logic [2:0] {
    PH_START,
    PH_LEAD,
    PH_HEX,
    PH_QUAD,
    PH_ERR
  } phase_e;

  // Parser state as it stands after the last character of one address.
  typedef struct packed {
    logic [NumBytes-1:0][7:0] bytes;
    logic [4:0]               wpos;
    logic [4:0]               gpos;
    logic                     gap;
    logic [15:0]              group;
    logic                     hex_seen;
    logic [2:0]               qcnt;
    logic                     q_seen;
    phase_e                   phase;
  } snap_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        ok;
  } result_t;

  // {is_hex_digit, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CharZero && c <= CharNine) begin
      r = {1'b1, 4'(c - CharZero)};
    end else if (c >= CharLowA && c <= CharLowF) begin
      r = {1'b1, 4'(c - CharLowA + 8'd10)};
    end else if (c >= CharUpA && c <= CharUpF) begin
      r = {1'b1, 4'(c - CharUpA + 8'd10)};
    end
    return r;
  endfunction

endpackage

// ===== hdl/ip6p_char_if.sv =====
// Character channel: one text character and its end-of-text flag per word.
`timescale 1ns / 1ps

interface ip6p_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

// ===== hdl/ip6p_half_if.sv =====
// Result channel: one 64-bit half of the binary address per word.
`timescale 1ns / 1ps

interface ip6p_half_if;
  logic        valid;
  logic        ready;
  logic [63:0] address_half;
  logic        is_low_half;
  logic        address_valid;

  modport source (output valid, output address_half, output is_low_half,
                  output address_valid, input ready);
  modport sink   (input valid, input address_half, input is_low_half,
                  input address_valid, output ready);
endinterface

// ===== hdl/ip6p_step.sv =====
// Per-character parser: accumulators, byte store and parse phase.
`timescale 1ns / 1ps

module ip6p_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  logic [7:0]     char_i,
  input  logic           last_i,
  output ip6p_pkg::snap_t snap_o
);
  import ip6p_pkg::*;

  logic [NumBytes-1:0][7:0] bytes_q, bytes_d;
  logic [4:0]  wpos_q, wpos_d;
  logic [4:0]  gpos_q, gpos_d;
  logic        gap_q, gap_d;
  logic [15:0] group_q, group_d;
  logic        hex_seen_q, hex_seen_d;
  logic [8:0]  dec_q, dec_d;
  logic        all_dec_q, all_dec_d;
  phase_e      phase_q, phase_d;
  logic [2:0]  qcnt_q, qcnt_d;
  logic        qseen_q, qseen_d;
  logic        ended_q, ended_d;

  logic [4:0]  hd;
  logic        is_dec;
  logic [11:0] dec_mul;
  logic [2:0]  qn;
  logic        wa_en, wb_en;
  logic [3:0]  wa_idx, wb_idx;
  logic [7:0]  wa_dat, wb_dat;

  assign hd      = hex_digit(char_i);
  assign is_dec  = hd[4] && (hd[3:0] < DecRadix);
  // dec * 10 + digit
  assign dec_mul = {dec_q, 3'b000} + {2'b00, dec_q, 1'b0} + {8'd0, hd[3:0]};

  always_comb begin
    wpos_d     = wpos_q;
    gpos_d     = gpos_q;
    gap_d      = gap_q;
    group_d    = group_q;
    hex_seen_d = hex_seen_q;
    dec_d      = dec_q;
    all_dec_d  = all_dec_q;
    phase_d    = phase_q;
    qcnt_d     = qcnt_q;
    qseen_d    = qseen_q;
    ended_d    = ended_q;
    qn         = qcnt_q;
    wa_en      = 1'b0;
    wb_en      = 1'b0;
    wa_idx     = wpos_q[3:0];
    wb_idx     = wpos_q[3:0] + 4'd1;
    wa_dat     = group_q[15:8];
    wb_dat     = group_q[7:0];

    if (!ended_q && phase_q != PH_ERR) begin
      if (char_i == CharNul) begin
        ended_d = 1'b1;   // text ends here, state frozen until the last word
      end else begin
        unique case (phase_q) inside
          PH_START, PH_HEX: begin
            if (phase_q == PH_START && char_i == CharColon) begin
              phase_d = PH_LEAD;
            end else begin
              phase_d = PH_HEX;
              if (hd[4]) begin
                if (group_q[15:12] != 4'd0) begin
                  phase_d = PH_ERR;
                end else begin
                  group_d    = {group_q[11:0], hd[3:0]};
                  hex_seen_d = 1'b1;
                  if (is_dec) begin
                    dec_d = (dec_mul > {3'b000, DecSat}) ? DecSat : dec_mul[8:0];
                  end else begin
                    all_dec_d = 1'b0;
                  end
                end
              end else if (char_i == CharColon) begin
                if (!hex_seen_q) begin
                  if (gap_q) begin
                    phase_d = PH_ERR;
                  end else begin
                    gap_d  = 1'b1;
                    gpos_d = wpos_q;
                  end
                end else if (wpos_q > 5'd14) begin
                  phase_d = PH_ERR;
                end else begin
                  wa_en  = 1'b1;
                  wb_en  = 1'b1;
                  wpos_d = wpos_q + 5'd2;
                end
                if (phase_d != PH_ERR) begin
                  group_d    = 16'd0;
                  hex_seen_d = 1'b0;
                  dec_d      = 9'd0;
                  all_dec_d  = 1'b1;
                end
              end else if (char_i == CharDot && wpos_q <= 5'd12 && hex_seen_q &&
                           all_dec_q && dec_q <= OctetMax) begin
                // first octet of a dotted-quad tail
                wa_en   = 1'b1;
                wa_dat  = dec_q[7:0];
                qcnt_d  = 3'd1;
                qseen_d = 1'b0;
                dec_d   = 9'd0;
                phase_d = PH_QUAD;
              end else begin
                phase_d = PH_ERR;
              end
            end
          end
          PH_LEAD: begin
            if (char_i == CharColon) begin
              gap_d      = 1'b1;
              gpos_d     = 5'd0;
              group_d    = 16'd0;
              hex_seen_d = 1'b0;
              dec_d      = 9'd0;
              all_dec_d  = 1'b1;
              phase_d    = PH_HEX;
            end else begin
              phase_d = PH_ERR;
            end
          end
          PH_QUAD: begin
            if (is_dec) begin
              if (dec_mul > {3'b000, OctetMax}) begin
                phase_d = PH_ERR;
              end else if (!qseen_q && qcnt_q >= 3'd4) begin
                phase_d = PH_ERR;
              end else begin
                qn      = qseen_q ? qcnt_q : qcnt_q + 3'd1;
                dec_d   = dec_mul[8:0];
                qcnt_d  = qn;
                qseen_d = 1'b1;
                wa_en   = 1'b1;
                wa_idx  = wpos_q[3:0] + {1'b0, qn} - 4'd1;
                wa_dat  = dec_mul[7:0];
              end
            end else if (char_i == CharDot && qseen_q) begin
              if (qcnt_q >= 3'd4) begin
                phase_d = PH_ERR;
              end else begin
                dec_d   = 9'd0;
                qseen_d = 1'b0;
              end
            end else begin
              phase_d = PH_ERR;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    bytes_d = bytes_q;
    for (int i = 0; i < NumBytes; i++) begin
      if (wa_en && wa_idx == 4'(i)) bytes_d[i] = wa_dat;
      if (wb_en && wb_idx == 4'(i)) bytes_d[i] = wb_dat;
    end
  end

  always_comb begin
    snap_o.bytes    = bytes_d;
    snap_o.wpos     = wpos_d;
    snap_o.gpos     = gpos_d;
    snap_o.gap      = gap_d;
    snap_o.group    = group_d;
    snap_o.hex_seen = hex_seen_d;
    snap_o.qcnt     = qcnt_d;
    snap_o.q_seen   = qseen_d;
    snap_o.phase    = phase_d;
  end

  // Byte store: every byte read at finish was written earlier in the same address.
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      bytes_q <= bytes_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q     <= 5'd0;
      gpos_q     <= 5'd0;
      gap_q      <= 1'b0;
      group_q    <= 16'd0;
      hex_seen_q <= 1'b0;
      dec_q      <= 9'd0;
      all_dec_q  <= 1'b1;
      phase_q    <= PH_START;
      qcnt_q     <= 3'd0;
      qseen_q    <= 1'b0;
      ended_q    <= 1'b0;
    end else if (take_i) begin
      if (last_i) begin
        wpos_q     <= 5'd0;
        gpos_q     <= 5'd0;
        gap_q      <= 1'b0;
        group_q    <= 16'd0;
        hex_seen_q <= 1'b0;
        dec_q      <= 9'd0;
        all_dec_q  <= 1'b1;
        phase_q    <= PH_START;
        qcnt_q     <= 3'd0;
        qseen_q    <= 1'b0;
        ended_q    <= 1'b0;
      end else begin
        wpos_q     <= wpos_d;
        gpos_q     <= gpos_d;
        gap_q      <= gap_d;
        group_q    <= group_d;
        hex_seen_q <= hex_seen_d;
        dec_q      <= dec_d;
        all_dec_q  <= all_dec_d;
        phase_q    <= phase_d;
        qcnt_q     <= qcnt_d;
        qseen_q    <= qseen_d;
        ended_q    <= ended_d;
      end
    end
  end

endmodule

// ===== hdl/ip6p_finish.sv =====
// End-of-text checks, gap expansion and link-local filter on a stored snapshot.
`timescale 1ns / 1ps

module ip6p_finish (
  input  ip6p_pkg::snap_t   snap_i,
  input  logic              reject_i,
  output ip6p_pkg::result_t res_o
);
  import ip6p_pkg::*;

  logic [NumBytes-1:0][7:0] b, t;
  logic [4:0] wp;
  logic [5:0] sh, lim;
  logic       ok;

  always_comb begin
    b  = snap_i.bytes;
    wp = snap_i.wpos;
    ok = 1'b1;

    case (snap_i.phase)
      PH_HEX: begin
        if (snap_i.hex_seen) begin
          // flush the open group
          if (wp > 5'd14) begin
            ok = 1'b0;
          end else begin
            b[wp[3:0]]         = snap_i.group[15:8];
            b[wp[3:0] + 4'd1]  = snap_i.group[7:0];
            wp                 = wp + 5'd2;
          end
        end else if (!(snap_i.gap && snap_i.gpos == wp)) begin
          ok = 1'b0;   // trailing single colon
        end
      end
      PH_QUAD: begin
        if (snap_i.qcnt != 3'd4 || !snap_i.q_seen) begin
          ok = 1'b0;
        end else begin
          wp = wp + 5'd4;
        end
      end
      default: ok = 1'b0;
    endcase

    sh  = 6'd16 - {1'b0, wp};
    lim = {1'b0, snap_i.gpos} + sh;
    t   = b;
    if (snap_i.gap) begin
      if (wp >= 5'd16 || snap_i.gpos > wp) ok = 1'b0;
      for (int i = 0; i < NumBytes; i++) begin
        if (6'(i) < {1'b0, snap_i.gpos}) begin
          t[i] = b[i];
        end else if (6'(i) < lim) begin
          t[i] = 8'd0;
        end else begin
          t[i] = b[4'(6'(i) - sh)];
        end
      end
    end else if (wp != 5'd16) begin
      ok = 1'b0;
    end

    if (reject_i && t[0] == LinkLocalB0 && t[1] == LinkLocalB1) ok = 1'b0;

    res_o.hi = 64'd0;
    res_o.lo = 64'd0;
    for (int i = 0; i < NumBytes / 2; i++) begin
      res_o.hi = {res_o.hi[55:0], t[i]};
      res_o.lo = {res_o.lo[55:0], t[i + NumBytes / 2]};
    end
    if (!ok) begin
      res_o.hi = 64'd0;
      res_o.lo = 64'd0;
    end
    res_o.ok = ok;
  end

endmodule

// ===== hdl/ip6p_resq.sv =====
// Two-entry result queue; sends each finished address as high then low half.
`timescale 1ns / 1ps

module ip6p_resq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ip6p_pkg::snap_t snap_i,
  input  logic            reject_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [63:0]     half_o,
  output logic            low_o,
  output logic            ok_o
);
  import ip6p_pkg::*;

  snap_t      slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       beat_q;
  logic       take, pop;
  result_t    res;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign take    = valid_o && ready_i;
  assign pop     = take && beat_q;

  ip6p_finish u_finish (
    .snap_i   (slot_q[rd_ptr_q]),
    .reject_i (reject_i),
    .res_o    (res)
  );

  assign half_o = beat_q ? res.lo : res.hi;
  assign low_o  = beat_q;
  assign ok_o   = res.ok;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop)      cnt_d = cnt_q + 2'd1;
    else if (!push_i && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= snap_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      beat_q   <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      if (take)   beat_q   <= ~beat_q;
    end
  end

endmodule

// ===== hdl/ipv6_text_address_parser_unit.sv =====
// An address's high half is offered after its snapshot is stored in the result queue.
// The low half follows as soon as the high half is taken.
// Throughput: one character word per cycle; input stalls only while two addresses wait.
// Reset: asynchronous, active low; parser and queue empty, link-local rejection on.
`timescale 1ns / 1ps

module ipv6_text_address_parser_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  ip6p_char_if.sink          in_i,
  ip6p_half_if.source        out_o
);
  import ip6p_pkg::*;

  // Config: reject addresses beginning fe80 when set.
  logic  reject_q;
  logic  full;
  logic  take;
  snap_t snap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reject_q <= 1'b1;
    end else if (cfg_we_i) begin
      reject_q <= cfg_wdata_i;
    end
  end

  // A character word is taken whenever the result queue has room.
  assign in_i.ready = !full;
  assign take       = in_i.valid && !full;

  // Character stage: each word updates the accumulators and byte store;
  // the last word hands the post-update state to the queue.
  ip6p_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .char_i (in_i.text_char),
    .last_i (in_i.end_of_text),
    .snap_o (snap)
  );

  // Result stage: final checks and gap expansion on the queue head,
  // two words per address.
  ip6p_resq u_resq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (take && in_i.end_of_text),
    .snap_i   (snap),
    .reject_i (reject_q),
    .full_o   (full),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .half_o   (out_o.address_half),
    .low_o    (out_o.is_low_half),
    .ok_o     (out_o.address_valid)
  );

endmodule

// ===== hdl/ip6p_checker.sv =====
// Port-level checks for the IPv6 text address parser, bound to the top level.
`timescale 1ns / 1ps

module ip6p_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        cfg_wdata_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_half_i,
  input logic        out_low_i,
  input logic        out_ok_i
);
  import ip6p_pkg::*;

  logic reject_q;
  logic hi_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reject_q <= 1'b1;
    end else if (cfg_we_i) begin
      reject_q <= cfg_wdata_i;
    end
  end

  assign hi_take = out_valid_i && out_ready_i && !out_low_i;

  // Low half is offered straight after the high half goes.
  a_low_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hi_take |=> (out_valid_i && out_low_i))
    else $error("low half not offered after high half");

  a_valid_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hi_take |=> (out_ok_i == $past(out_ok_i)))
    else $error("halves of one address disagree on validity");

  a_zero_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ok_i) |-> (out_half_i == 64'd0))
    else $error("invalid address with non-zero half");

  a_link_local: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ok_i && !out_low_i && reject_q) |->
      (out_half_i[63:48] != {LinkLocalB0, LinkLocalB1}))
    else $error("link-local address passed while rejection is on");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_half_i)))
    else $error("stalled result word changed");

endmodule

bind ipv6_text_address_parser_unit ip6p_checker u_ip6p_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_half_i  (out_o.address_half),
  .out_low_i   (out_o.is_low_half),
  .out_ok_i    (out_o.address_valid)
);

// ===== tb/sv/ipv6_text_address_parser_unit_tb.sv =====
// Self-checking bench: random and directed IPv6 text fed per character, halves checked in order.
`timescale 1ns / 1ps

module ipv6_text_address_parser_unit_tb;
  import ip6p_pkg::*;

  // One character word and one expected output half.
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } char_word_t;

  typedef struct packed {
    logic [63:0] half;
    logic        low;
    logic        ok;
  } half_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  ip6p_char_if chan_in ();
  ip6p_half_if chan_out ();

  ipv6_text_address_parser_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (chan_in),
    .out_o       (chan_out)
  );

  always #5 clk = ~clk;

  // Stimulus and scoreboard storage.
  char_word_t pending_chars [$];
  half_word_t expected_halves [$];
  logic [7:0] text_buf [$];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_sender;
  bit  char_taken;
  int  mismatches;

  // Shadow of the parser: address bytes, token accumulators and scan phase.
  logic [7:0]  addr_bytes [16];
  int unsigned wr_pos;
  int unsigned gap_pos;
  bit          has_gap;
  logic [15:0] group_acc;
  bit          group_has_digit;
  int unsigned dec_acc;
  bit          dec_only;
  phase_e      scan_phase;
  bit          scan_done;
  int unsigned octet_cnt;
  bit          octet_has_digit;
  bit          reject_ll;

  task automatic report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void clear_scan();
    foreach (addr_bytes[i]) addr_bytes[i] = 8'h00;
    wr_pos          = 0;
    gap_pos         = 0;
    has_gap         = 1'b0;
    group_acc       = 16'h0000;
    group_has_digit = 1'b0;
    dec_acc         = 0;
    dec_only        = 1'b1;
    scan_phase      = PH_START;
    scan_done       = 1'b0;
    octet_cnt       = 0;
    octet_has_digit = 1'b0;
  endfunction

  function automatic void restart_token();
    group_acc       = 16'h0000;
    group_has_digit = 1'b0;
    dec_acc         = 0;
    dec_only        = 1'b1;
  endfunction

  function automatic void put_group();
    addr_bytes[wr_pos % 16]       = group_acc[15:8];
    addr_bytes[(wr_pos + 1) % 16] = group_acc[7:0];
    wr_pos += 2;
  endfunction

  // Character inside a hex group, at a colon, or at the dot opening an IPv4 tail.
  function automatic void scan_hex(logic [7:0] c);
    int          d;
    int unsigned v;
    d = -1;
    if (c >= CharZero && c <= CharNine) d = c - CharZero;
    else if (c >= CharLowA && c <= CharLowF) d = c - CharLowA + 10;
    else if (c >= CharUpA && c <= CharUpF) d = c - CharUpA + 10;
    if (d >= 0) begin
      if (group_acc[15:12] != 4'h0) begin
        scan_phase = PH_ERR;
        return;
      end
      group_acc       = {group_acc[11:0], 4'(d)};
      group_has_digit = 1'b1;
      if (d < 10) begin
        v       = dec_acc * 10 + d;
        dec_acc = (v > 256) ? 256 : v;
      end else begin
        dec_only = 1'b0;
      end
      return;
    end
    if (c == CharColon) begin
      if (!group_has_digit) begin
        // second colon of a gap; only one gap per address
        if (has_gap) begin
          scan_phase = PH_ERR;
          return;
        end
        has_gap = 1'b1;
        gap_pos = wr_pos;
      end else begin
        if (wr_pos > 14) begin
          scan_phase = PH_ERR;
          return;
        end
        put_group();
      end
      restart_token();
      return;
    end
    if (c == CharDot && wr_pos <= 12 && group_has_digit && dec_only && dec_acc <= 255) begin
      addr_bytes[wr_pos % 16] = dec_acc[7:0];
      octet_cnt       = 1;
      octet_has_digit = 1'b0;
      dec_acc         = 0;
      scan_phase      = PH_QUAD;
      return;
    end
    scan_phase = PH_ERR;
  endfunction

  // Character in the dotted-quad tail, after its first octet.
  function automatic void scan_quad(logic [7:0] c);
    int unsigned v;
    if (c >= CharZero && c <= CharNine) begin
      v = dec_acc * 10 + (c - CharZero);
      if (v > 255) begin
        scan_phase = PH_ERR;
        return;
      end
      dec_acc = v;
      if (!octet_has_digit) begin
        if (octet_cnt >= 4) begin
          scan_phase = PH_ERR;
          return;
        end
        octet_cnt++;
        octet_has_digit = 1'b1;
      end
      addr_bytes[(wr_pos + octet_cnt - 1) % 16] = v[7:0];
      return;
    end
    if (c == CharDot && octet_has_digit) begin
      if (octet_cnt >= 4) begin
        scan_phase = PH_ERR;
        return;
      end
      dec_acc         = 0;
      octet_has_digit = 1'b0;
      return;
    end
    scan_phase = PH_ERR;
  endfunction

  // End of text: flush the open token, expand the gap, apply the link-local rule.
  function automatic void close_scan();
    logic [7:0]  t [16];
    int unsigned shift;
    if (scan_phase == PH_HEX) begin
      if (group_has_digit) begin
        if (wr_pos > 14) begin
          scan_phase = PH_ERR;
          return;
        end
        put_group();
      end else if (!(has_gap && gap_pos == wr_pos)) begin
        // trailing single colon
        scan_phase = PH_ERR;
        return;
      end
    end else if (scan_phase == PH_QUAD) begin
      if (octet_cnt != 4 || !octet_has_digit) begin
        scan_phase = PH_ERR;
        return;
      end
      wr_pos += 4;
    end else begin
      scan_phase = PH_ERR;
      return;
    end
    if (has_gap) begin
      if (wr_pos >= 16 || gap_pos > wr_pos) begin
        scan_phase = PH_ERR;
        return;
      end
      shift = 16 - wr_pos;
      for (int i = 0; i < 16; i++) begin
        if (i < gap_pos) t[i] = addr_bytes[i];
        else if (i < gap_pos + shift) t[i] = 8'h00;
        else t[i] = addr_bytes[(i - shift) % 16];
      end
      addr_bytes = t;
      wr_pos     = 16;
      has_gap    = 1'b0;
    end
    if (wr_pos != 16) begin
      scan_phase = PH_ERR;
      return;
    end
    if (reject_ll && addr_bytes[0] == LinkLocalB0 && addr_bytes[1] == LinkLocalB1) begin
      scan_phase = PH_ERR;
      return;
    end
    scan_done = 1'b1;
  endfunction

  // Advance the shadow parser by one accepted word; queue both halves on end of text.
  function automatic void predict_char(logic [7:0] c, logic eot);
    logic [63:0] hi;
    logic [63:0] lo;
    half_word_t  w;
    bit          ok;
    if (!scan_done && scan_phase != PH_ERR) begin
      if (c == CharNul) begin
        close_scan();
      end else begin
        case (scan_phase)
          PH_START: begin
            if (c == CharColon) begin
              scan_phase = PH_LEAD;
            end else begin
              scan_phase = PH_HEX;
              scan_hex(c);
            end
          end
          PH_LEAD: begin
            if (c == CharColon) begin
              has_gap = 1'b1;
              gap_pos = 0;
              restart_token();
              scan_phase = PH_HEX;
            end else begin
              scan_phase = PH_ERR;
            end
          end
          PH_HEX:  scan_hex(c);
          PH_QUAD: scan_quad(c);
          default: scan_phase = PH_ERR;
        endcase
      end
    end
    if (!eot) return;
    if (!scan_done && scan_phase != PH_ERR) close_scan();
    ok = scan_done;
    hi = '0;
    lo = '0;
    if (ok) begin
      for (int i = 0; i < 8; i++) begin
        hi = {hi[55:0], addr_bytes[i]};
        lo = {lo[55:0], addr_bytes[i + 8]};
      end
    end
    w.half = hi;
    w.low  = 1'b0;
    w.ok   = ok;
    expected_halves.insert(expected_halves.size(), w);
    w.half = lo;
    w.low  = 1'b1;
    expected_halves.insert(expected_halves.size(), w);
    clear_scan();
  endfunction

  // ---- text building ----

  function automatic void put_char(logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endfunction

  function automatic void queue_text();
    char_word_t w;
    foreach (text_buf[i]) begin
      w.ch  = text_buf[i];
      w.eot = (i == text_buf.size() - 1);
      pending_chars.insert(pending_chars.size(), w);
    end
    text_buf.delete();
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  function automatic void queue_str(string s);
    add_str(s);
    queue_text();
  endfunction

  function automatic logic [7:0] odd_char();
    case ($urandom_range(7))
      0:       return CharColon;
      1:       return CharDot;
      2:       return 8'(CharZero + $urandom_range(9));
      3:       return 8'(CharLowA + $urandom_range(5));
      4:       return 8'(CharUpA + $urandom_range(5));
      5:       return "g";
      6:       return CharNul;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic int unsigned pick_group();
    case ($urandom_range(3))
      0:       return 0;
      1:       return $urandom_range(15);
      2:       return $urandom_range(255);
      default: return $urandom_range(16'hffff);
    endcase
  endfunction

  // Hex group in mixed case, sometimes padded with leading zeros.
  function automatic void add_group(int unsigned v);
    int         n;
    int         width;
    logic [3:0] nib;
    n = (v > 16'hfff) ? 4 : (v > 8'hff) ? 3 : (v > 4'hf) ? 2 : 1;
    width = n + $urandom_range(4 - n);
    if ($urandom_range(9) == 0) width++;
    for (int k = width - 1; k >= 0; k--) begin
      nib = 4'(v >> (4 * k));
      if (nib < 10) put_char(8'(CharZero + nib));
      else put_char(8'(($urandom_range(1) ? CharUpA : CharLowA) + nib - 10));
    end
  endfunction

  function automatic void add_octet(int unsigned v);
    if ($urandom_range(5) == 0) put_char(CharZero);
    if (v >= 100) put_char(8'(CharZero + v / 100));
    if (v >= 10) put_char(8'(CharZero + (v / 10) % 10));
    put_char(8'(CharZero + v % 10));
  endfunction

  // Well-formed shape: eight groups, or a gap with fewer, with or without an IPv4 tail.
  // A gap next to a full set of groups slips through now and then and must fail.
  function automatic void build_address();
    bit v4;
    bit gap;
    bit ll;
    int slots;
    int k;
    int left;
    int right;
    v4    = ($urandom_range(3) == 0);
    gap   = $urandom_range(1);
    ll    = ($urandom_range(4) == 0);
    slots = v4 ? 6 : 8;
    if (gap) begin
      k     = $urandom_range(slots);
      left  = $urandom_range(k);
      right = k - left;
      for (int i = 0; i < left; i++) begin
        if (i > 0) put_char(CharColon);
        add_group((i == 0 && ll) ? 16'hfe80 : pick_group());
      end
      add_str("::");
      for (int i = 0; i < right; i++) begin
        if (i > 0) put_char(CharColon);
        add_group(pick_group());
      end
      if (v4 && right > 0) put_char(CharColon);
    end else begin
      for (int i = 0; i < slots; i++) begin
        if (i > 0) put_char(CharColon);
        add_group((i == 0 && ll) ? 16'hfe80 : pick_group());
      end
      if (v4) put_char(CharColon);
    end
    if (v4) begin
      for (int i = 0; i < 4; i++) begin
        if (i > 0) put_char(CharDot);
        add_octet($urandom_range(255));
      end
    end
  endfunction

  // Mostly well-formed addresses; the rest damaged copies and loose noise.
  function automatic void fill_random(int budget);
    int used;
    int pick;
    int pos;
    used = 0;
    while (used < budget) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        build_address();
        if ($urandom_range(7) == 0) begin
          // zero ends the text early; what follows is ignored
          put_char(CharNul);
          repeat ($urandom_range(3)) put_char(odd_char());
        end
      end else if (pick < 88) begin
        build_address();
        repeat ($urandom_range(1, 2)) begin
          pos = $urandom_range(text_buf.size() - 1);
          case ($urandom_range(2))
            0: text_buf[pos] = odd_char();
            1: if (text_buf.size() > 1) text_buf.delete(pos);
            default: text_buf.insert(pos, odd_char());
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 10)) put_char(odd_char());
      end
      used += text_buf.size();
      queue_text();
    end
  endfunction

  function automatic void fill_directed();
    queue_str("::");
    queue_str("fe80::1");
    queue_str("FE80:0:0:0:0:0:0:1");
    queue_str("1:2:3:4:5:6:7:8");
    queue_str("ffff:FFFF:abcd:ABCD:0:0:0:0");
    queue_str("0000ffff::");
    queue_str("1ffff::");
    queue_str("::ffff:192.168.0.1");
    queue_str("1:2:3:4:5:6:255.255.255.255");
    queue_str("::1.2.3.256");
    queue_str("::256.1.1.1");
    queue_str("::1.2.3");
    queue_str("::1.2.3.4.5");
    queue_str("::1..2.3");
    queue_str("::1a.2.3.4");
    queue_str("1:2:3:4:5:6:7:1.2.3.4");
    queue_str("::001.002.003.004");
    queue_str(":1::");
    queue_str(":");
    queue_str("1:2:");
    queue_str("1:2:3:4::5:6:7:8");
    queue_str("1:2:3:4:5:6:7:8:9");
    queue_str("1::2::3");
    queue_str("12g4::");
    queue_str("1:2:3:4:5:6:7::");
    queue_str("::1:2:3:4:5:6:7");
    // empty text: zero as the only character
    put_char(CharNul);
    queue_text();
    // zero mid-text, then junk up to end of text
    add_str("2001:db8::1");
    put_char(CharNul);
    add_str("zz");
    queue_text();
    // zero carrying end of text is not part of the address
    add_str("::1");
    put_char(CharNul);
    queue_text();
    put_char(8'hff);
    queue_text();
  endfunction

  // ---- driver, ready and monitor ----

  always @(negedge clk) begin : drive_chars
    char_word_t nxt;
    if (rst_n) begin
      if (!chan_in.valid || char_taken) begin
        if (pending_chars.size() != 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_chars.pop_front();
          chan_in.valid       <= 1'b1;
          chan_in.text_char   <= nxt.ch;
          chan_in.end_of_text <= nxt.eot;
        end else begin
          chan_in.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) chan_out.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : watch_ports
    half_word_t want;
    char_taken = 1'b0;
    if (rst_n) begin
      if (chan_out.valid && chan_out.ready) begin
        if (expected_halves.size() == 0) begin
          report_mismatch($sformatf("half %h low %b with nothing expected",
                                    chan_out.address_half, chan_out.is_low_half));
        end else begin
          want = expected_halves.pop_front();
          if (chan_out.address_half !== want.half)
            report_mismatch($sformatf("address_half %h, expected %h",
                                      chan_out.address_half, want.half));
          if (chan_out.is_low_half !== want.low)
            report_mismatch($sformatf("is_low_half %b, expected %b",
                                      chan_out.is_low_half, want.low));
          if (chan_out.address_valid !== want.ok)
            report_mismatch($sformatf("address_valid %b, expected %b",
                                      chan_out.address_valid, want.ok));
        end
      end
      if (chan_in.valid && chan_in.ready) begin
        char_taken = 1'b1;
        predict_char(chan_in.text_char, chan_in.end_of_text);
      end
    end
  end

  // ---- sequencing ----

  task automatic wait_drained();
    while (pending_chars.size() != 0 || chan_in.valid || expected_halves.size() != 0)
      @(negedge clk);
    // a word that yields no half may still be in flight; give it the pipeline depth
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reject(bit v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    reject_ll = v;
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = 1'b0;
    chan_in.valid       = 1'b0;
    chan_in.text_char   = 8'h00;
    chan_in.end_of_text = 1'b0;
    chan_out.ready      = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_sender         = 1'b0;
    char_taken          = 1'b0;
    mismatches          = 0;
    reject_ll           = 1'b1;
    clear_scan();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed set with link-local rejection at its reset value
    fill_directed();
    wait_drained();

    // random phases: idle mix and rejection bit change between them
    for (int p = 0; p < 4; p++) begin
      set_reject(p % 2 == 1);
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if (p == 0) begin
        queue_str("fe80::1");
        queue_str("FE80:0:0:0:0:0:0:1");
      end
      fill_random(370);
      if (p == 3) begin
        // sender holds off mid-stream until every queued half has been taken
        while (pending_chars.size() > 185) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_halves.size() != 0 || chan_in.valid) @(negedge clk);
        @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Timeout far beyond the slowest run.
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ip6p_pkg.sv
hdl/ip6p_char_if.sv
hdl/ip6p_half_if.sv
hdl/ip6p_step.sv
hdl/ip6p_finish.sv
hdl/ip6p_resq.sv
hdl/ipv6_text_address_parser_unit.sv
hdl/ip6p_checker.sv
tb/sv/ipv6_text_address_parser_unit_tb.sv
